FILE: src/nfcs_pkg.sv
package nfcs_pkg;

   // field widths of the request and result items
   localparam int AddrWidth = 22;
   localparam int DataWidth = 8;
   localparam int OpWidth = 3;
   localparam int KindWidth = 3;
   localparam int CountWidth = 28;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 28;
   localparam int AddressBitsDefault = 22;

   // most results a single request can cause
   localparam int MaxResults = 7;
   localparam int ResultIdxWidth = 3;

   // register reset values
   localparam logic [AddrWidth-1:0] UnlockFirstReset = 22'h000AAA;
   localparam logic [AddrWidth-1:0] UnlockSecondReset = 22'h000555;
   localparam logic [CountWidth-1:0] PollLimitReset = 28'hFFFFFFF;

   // flash command bytes
   localparam logic [DataWidth-1:0] CmdUnlock1 = 8'hAA;
   localparam logic [DataWidth-1:0] CmdUnlock2 = 8'h55;
   localparam logic [DataWidth-1:0] CmdEraseSetup = 8'h80;
   localparam logic [DataWidth-1:0] CmdChipErase = 8'h10;
   localparam logic [DataWidth-1:0] CmdSectorErase = 8'h30;
   localparam logic [DataWidth-1:0] CmdProgram = 8'hA0;
   localparam logic [DataWidth-1:0] CmdReset = 8'hF0;
   localparam int ToggleBit = 6;
   localparam int ReadyBit = 7;

   // register indexes on the csr port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_UNLOCK_FIRST  = 2'd0,
      CSR_UNLOCK_SECOND = 2'd1,
      CSR_POLL_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [OpWidth-1:0] {
      OP_PROGRAM      = 3'd0,
      OP_SECTOR_ERASE = 3'd1,
      OP_CHIP_ERASE   = 3'd2,
      OP_RESET_READ   = 3'd3,
      OP_READ_DATA    = 3'd4
   } op_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_WRITE   = 3'd0,
      KIND_READ    = 3'd1,
      KIND_DONE    = 3'd2,
      KIND_TIMEOUT = 3'd3,
      KIND_REJECT  = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      WAIT_IDLE       = 5'b00001,
      WAIT_PROGRAM    = 5'b00010,
      WAIT_TOGGLE_REF = 5'b00100,
      WAIT_TOGGLE     = 5'b01000,
      WAIT_CHIP       = 5'b10000
   } wait_mode_type;

   typedef struct packed {
      kind_type               kind;
      logic [AddrWidth-1:0]   addr;
      logic [DataWidth-1:0]   data;
   } result_type;

   function automatic result_type make_result(kind_type kind, logic [AddrWidth-1:0] addr,
                                              logic [DataWidth-1:0] data);
      result_type r;
      r.kind = kind;
      r.addr = addr;
      r.data = data;
      return r;
   endfunction

endpackage

FILE: src/nfcs_req_if.sv
interface nfcs_req_if import nfcs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [OpWidth-1:0]   op;
   logic [AddrWidth-1:0] address;
   logic [DataWidth-1:0] data;

   modport source (output valid, output op, output address, output data, input ready);
   modport sink (input valid, input op, input address, input data, output ready);
endinterface

FILE: src/nfcs_rsp_if.sv
interface nfcs_rsp_if import nfcs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] kind;
   logic [AddrWidth-1:0] bus_address;
   logic [DataWidth-1:0] bus_data;
   logic                 last;

   modport source (output valid, output kind, output bus_address, output bus_data,
                   output last, input ready);
   modport sink (input valid, input kind, input bus_address, input bus_data,
                 input last, output ready);
endinterface

FILE: src/nor_flash_command_sequencer.sv
// Host-side command sequencer for an AMD-style NOR flash. A request is either a command
// (program byte, sector erase, chip erase, reset to read) or a byte returned by a status
// read. In the cycle a request is accepted its whole result list (bus writes, the next
// polling read, done, timeout or rejected) is worked out and loaded into a result buffer,
// which then drains one result per cycle while rsp_ch.ready is high, the final one flagged
// by last. The result list holds 5 results for program, 7 for an erase, 2 for reset to
// read, 1 or 2 for returned read data and 1 for a rejected request. A new request is
// taken in the same cycle the final result of the previous one is taken, so back-to-back
// requests see no bubble. Polling waits time out after poll_limit counted reads (one if
// poll_limit is zero); the reference read of a sector erase is not counted.
// The csr registers should be written only while no results are pending.
module nor_flash_command_sequencer import nfcs_pkg::*; #(
   parameter int ADDRESS_BITS = AddressBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   nfcs_req_if.sink                 req_ch,
   nfcs_rsp_if.source               rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int KeepBits = (ADDRESS_BITS < AddrWidth) ? ADDRESS_BITS : AddrWidth;
   localparam logic [AddrWidth-1:0] AddrMask =
      AddrWidth'((64'(1) << KeepBits) - 64'(1));
   localparam logic [AddrWidth-1:0] ZeroAddr = '0;
   localparam logic [DataWidth-1:0] ZeroData = '0;

   // configuration registers
   logic [AddrWidth-1:0]  unlock1_ff;
   logic [AddrWidth-1:0]  unlock2_ff;
   logic [CountWidth-1:0] poll_limit_ff;

   // wait state
   wait_mode_type         wait_mode_ff, wait_mode_in;
   logic [DataWidth-1:0]  expected_ff, expected_in;
   logic [AddrWidth-1:0]  poll_addr_ff, poll_addr_in;
   logic                  prev_bit_ff, prev_bit_in;
   logic [CountWidth-1:0] poll_count_ff, poll_count_in;

   // result buffer
   result_type                result_ff [MaxResults];
   result_type                result_in [MaxResults];
   logic [ResultIdxWidth-1:0] idx_ff;
   logic [ResultIdxWidth-1:0] last_idx_ff, last_idx_in;
   logic                      busy_ff;

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  rsp_last;
   logic [AddrWidth-1:0]  req_addr;
   logic [AddrWidth-1:0]  u1;
   logic [AddrWidth-1:0]  u2;
   logic [CountWidth-1:0] count_next;
   logic                  expired;
   logic                  cur_bit;
   result_type            cur;

   // handshakes
   assign rsp_last = (idx_ff == last_idx_ff);
   assign rsp_fire = busy_ff && rsp_ch.ready;
   assign req_ch.ready = !busy_ff || (rsp_ch.ready && rsp_last);
   assign req_fire = req_ch.valid && req_ch.ready;

   // masked addresses and poll counter
   assign req_addr = req_ch.address & AddrMask;
   assign u1 = unlock1_ff & AddrMask;
   assign u2 = unlock2_ff & AddrMask;
   assign count_next = poll_count_ff + CountWidth'(1);
   assign expired = (count_next >= poll_limit_ff);
   assign cur_bit = req_ch.data[ToggleBit];

   // build the result list for the request
   always_comb begin
      wait_mode_in = wait_mode_ff;
      expected_in = expected_ff;
      poll_addr_in = poll_addr_ff;
      prev_bit_in = prev_bit_ff;
      poll_count_in = poll_count_ff;
      last_idx_in = '0;
      for (int i = 0; i < MaxResults; i++) begin
         result_in[i] = make_result(KIND_REJECT, ZeroAddr, ZeroData);
      end

      if (req_ch.op == OP_READ_DATA) begin
         // returned status byte, judged against the pending wait
         unique case (wait_mode_ff)
            WAIT_PROGRAM: begin
               if (req_ch.data == expected_ff) begin
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_DONE, poll_addr_ff, ZeroData);
               end else if (expired) begin
                  poll_count_in = count_next;
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_TIMEOUT, poll_addr_ff, ZeroData);
               end else begin
                  poll_count_in = count_next;
                  result_in[0] = make_result(KIND_READ, poll_addr_ff, ZeroData);
               end
            end
            WAIT_TOGGLE_REF: begin
               prev_bit_in = cur_bit;
               wait_mode_in = WAIT_TOGGLE;
               result_in[0] = make_result(KIND_READ, poll_addr_ff, ZeroData);
            end
            WAIT_TOGGLE: begin
               prev_bit_in = cur_bit;
               if (cur_bit == prev_bit_ff) begin
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_WRITE, ZeroAddr, CmdReset);
                  result_in[1] = make_result(KIND_DONE, poll_addr_ff, ZeroData);
                  last_idx_in = 3'd1;
               end else if (expired) begin
                  poll_count_in = count_next;
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_WRITE, ZeroAddr, CmdReset);
                  result_in[1] = make_result(KIND_TIMEOUT, poll_addr_ff, ZeroData);
                  last_idx_in = 3'd1;
               end else begin
                  poll_count_in = count_next;
                  result_in[0] = make_result(KIND_READ, poll_addr_ff, ZeroData);
               end
            end
            WAIT_CHIP: begin
               if (req_ch.data[ReadyBit]) begin
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_WRITE, ZeroAddr, CmdReset);
                  result_in[1] = make_result(KIND_DONE, poll_addr_ff, ZeroData);
                  last_idx_in = 3'd1;
               end else if (expired) begin
                  poll_count_in = count_next;
                  wait_mode_in = WAIT_IDLE;
                  result_in[0] = make_result(KIND_WRITE, ZeroAddr, CmdReset);
                  result_in[1] = make_result(KIND_TIMEOUT, poll_addr_ff, ZeroData);
                  last_idx_in = 3'd1;
               end else begin
                  poll_count_in = count_next;
                  result_in[0] = make_result(KIND_READ, poll_addr_ff, ZeroData);
               end
            end
            default: begin
               // read data with no wait pending: rejected
            end
         endcase
      end else if (wait_mode_ff == WAIT_IDLE) begin
         unique case (req_ch.op)
            OP_PROGRAM: begin
               result_in[0] = make_result(KIND_WRITE, u1, CmdUnlock1);
               result_in[1] = make_result(KIND_WRITE, u2, CmdUnlock2);
               result_in[2] = make_result(KIND_WRITE, u1, CmdProgram);
               result_in[3] = make_result(KIND_WRITE, req_addr, req_ch.data);
               result_in[4] = make_result(KIND_READ, req_addr, ZeroData);
               last_idx_in = 3'd4;
               expected_in = req_ch.data;
               wait_mode_in = WAIT_PROGRAM;
               poll_addr_in = req_addr;
               poll_count_in = '0;
            end
            OP_SECTOR_ERASE, OP_CHIP_ERASE: begin
               result_in[0] = make_result(KIND_WRITE, u1, CmdUnlock1);
               result_in[1] = make_result(KIND_WRITE, u2, CmdUnlock2);
               result_in[2] = make_result(KIND_WRITE, u1, CmdEraseSetup);
               result_in[3] = make_result(KIND_WRITE, u1, CmdUnlock1);
               result_in[4] = make_result(KIND_WRITE, u2, CmdUnlock2);
               if (req_ch.op == OP_SECTOR_ERASE) begin
                  result_in[5] = make_result(KIND_WRITE, req_addr, CmdSectorErase);
                  wait_mode_in = WAIT_TOGGLE_REF;
               end else begin
                  result_in[5] = make_result(KIND_WRITE, u1, CmdChipErase);
                  wait_mode_in = WAIT_CHIP;
               end
               result_in[6] = make_result(KIND_READ, ZeroAddr, ZeroData);
               last_idx_in = 3'd6;
               poll_addr_in = ZeroAddr;
               poll_count_in = '0;
            end
            OP_RESET_READ: begin
               result_in[0] = make_result(KIND_WRITE, ZeroAddr, CmdReset);
               result_in[1] = make_result(KIND_DONE, ZeroAddr, ZeroData);
               last_idx_in = 3'd1;
            end
            default: begin
               // unknown op: rejected
            end
         endcase
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock1_ff <= UnlockFirstReset;
         unlock2_ff <= UnlockSecondReset;
         poll_limit_ff <= PollLimitReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UNLOCK_FIRST:  unlock1_ff <= csr_wdata[AddrWidth-1:0];
            CSR_UNLOCK_SECOND: unlock2_ff <= csr_wdata[AddrWidth-1:0];
            CSR_POLL_LIMIT:    poll_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // wait state, updated when a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_mode_ff <= WAIT_IDLE;
         expected_ff <= '0;
         poll_addr_ff <= '0;
         prev_bit_ff <= 1'b0;
         poll_count_ff <= '0;
      end else if (req_fire) begin
         wait_mode_ff <= wait_mode_in;
         expected_ff <= expected_in;
         poll_addr_ff <= poll_addr_in;
         prev_bit_ff <= prev_bit_in;
         poll_count_ff <= poll_count_in;
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         last_idx_ff <= '0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
         idx_ff <= '0;
         last_idx_ff <= last_idx_in;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            busy_ff <= 1'b0;
         end
         idx_ff <= idx_ff + ResultIdxWidth'(1);
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MaxResults; i++) begin
            result_ff[i] <= result_in[i];
         end
      end
   end

   // result channel
   assign cur = result_ff[idx_ff];
   assign rsp_ch.valid = busy_ff;
   assign rsp_ch.kind = cur.kind;
   assign rsp_ch.bus_address = cur.addr;
   assign rsp_ch.bus_data = cur.data;
   assign rsp_ch.last = rsp_last;

endmodule

FILE: verif/nfcs_bus_checker.sv
module nfcs_bus_checker import nfcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   nfcs_req_if                      req_ch,
   nfcs_rsp_if                      rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output int                       mismatch_count,
   output int                       outstanding_count,
   output int                       request_count,
   output int                       result_count,
   output int                       done_count,
   output int                       timeout_count,
   output int                       reject_count
);

   localparam int MaxPrinted = 40;

   typedef struct packed {
      kind_type             kind;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] data;
      logic                 last;
   } bus_op_type;

   // shadow copy of the registers
   logic [AddrWidth-1:0]  unlock_first;
   logic [AddrWidth-1:0]  unlock_second;
   logic [CountWidth-1:0] poll_limit;

   // shadow copy of the polling state
   wait_mode_type         wait_mode;
   logic [DataWidth-1:0]  expected_byte;
   logic [AddrWidth-1:0]  poll_address;
   logic                  prev_toggle;
   logic [CountWidth-1:0] poll_count;

   bus_op_type expected_bus_ops[$];
   bus_op_type step_ops[MaxResults];
   int         step_len;
   bus_op_type want;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_value);
      if (mismatch_count < MaxPrinted) begin
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  result_count, what, got, want_value);
      end
      mismatch_count++;
   endtask

   function automatic void add_op(kind_type kind, logic [AddrWidth-1:0] addr,
                                  logic [DataWidth-1:0] data);
      step_ops[step_len].kind = kind;
      step_ops[step_len].addr = addr;
      step_ops[step_len].data = data;
      step_ops[step_len].last = 1'b0;
      step_len++;
   endfunction

   // counted polling read; the counter wraps at its width
   function automatic logic poll_expired();
      poll_count = poll_count + 1'b1;
      return poll_count >= poll_limit;
   endfunction

   // judge a returned status byte against the pending wait
   function automatic void resolve_poll(logic [DataWidth-1:0] data);
      logic settled;
      logic toggle_now;
      case (wait_mode)
         WAIT_PROGRAM: begin
            if (data == expected_byte) begin
               wait_mode = WAIT_IDLE;
               add_op(KIND_DONE, poll_address, '0);
            end else if (poll_expired()) begin
               wait_mode = WAIT_IDLE;
               add_op(KIND_TIMEOUT, poll_address, '0);
            end else begin
               add_op(KIND_READ, poll_address, '0);
            end
         end
         WAIT_TOGGLE_REF: begin
            prev_toggle = data[ToggleBit];
            wait_mode = WAIT_TOGGLE;
            add_op(KIND_READ, poll_address, '0);
         end
         WAIT_TOGGLE, WAIT_CHIP: begin
            if (wait_mode == WAIT_TOGGLE) begin
               toggle_now = data[ToggleBit];
               settled = (toggle_now == prev_toggle);
               prev_toggle = toggle_now;
            end else begin
               settled = data[ReadyBit];
            end
            if (settled) begin
               wait_mode = WAIT_IDLE;
               add_op(KIND_WRITE, '0, CmdReset);
               add_op(KIND_DONE, poll_address, '0);
            end else if (poll_expired()) begin
               wait_mode = WAIT_IDLE;
               add_op(KIND_WRITE, '0, CmdReset);
               add_op(KIND_TIMEOUT, poll_address, '0);
            end else begin
               add_op(KIND_READ, poll_address, '0);
            end
         end
         default: begin
            add_op(KIND_REJECT, '0, '0);
         end
      endcase
   endfunction

   // expected bus accesses and status for one request
   function automatic void predict_bus_sequence(logic [OpWidth-1:0] op,
                                                logic [AddrWidth-1:0] addr,
                                                logic [DataWidth-1:0] data);
      step_len = 0;
      if (op == OP_READ_DATA) begin
         resolve_poll(data);
      end else if (op > OP_READ_DATA || wait_mode != WAIT_IDLE) begin
         add_op(KIND_REJECT, '0, '0);
      end else if (op == OP_PROGRAM) begin
         add_op(KIND_WRITE, unlock_first, CmdUnlock1);
         add_op(KIND_WRITE, unlock_second, CmdUnlock2);
         add_op(KIND_WRITE, unlock_first, CmdProgram);
         add_op(KIND_WRITE, addr, data);
         expected_byte = data;
         wait_mode = WAIT_PROGRAM;
         poll_address = addr;
         poll_count = '0;
         add_op(KIND_READ, poll_address, '0);
      end else if (op == OP_SECTOR_ERASE || op == OP_CHIP_ERASE) begin
         add_op(KIND_WRITE, unlock_first, CmdUnlock1);
         add_op(KIND_WRITE, unlock_second, CmdUnlock2);
         add_op(KIND_WRITE, unlock_first, CmdEraseSetup);
         add_op(KIND_WRITE, unlock_first, CmdUnlock1);
         add_op(KIND_WRITE, unlock_second, CmdUnlock2);
         if (op == OP_SECTOR_ERASE) begin
            add_op(KIND_WRITE, addr, CmdSectorErase);
            wait_mode = WAIT_TOGGLE_REF;
         end else begin
            add_op(KIND_WRITE, unlock_first, CmdChipErase);
            wait_mode = WAIT_CHIP;
         end
         poll_address = '0;
         poll_count = '0;
         add_op(KIND_READ, poll_address, '0);
      end else begin
         add_op(KIND_WRITE, '0, CmdReset);
         add_op(KIND_DONE, '0, '0);
      end
      step_ops[step_len-1].last = 1'b1;
      for (int i = 0; i < step_len; i++) begin
         expected_bus_ops.push_back(step_ops[i]);
      end
   endfunction

   // register writes, result compare, then prediction of new requests
   always @(posedge clock) begin
      if (reset) begin
         unlock_first = UnlockFirstReset;
         unlock_second = UnlockSecondReset;
         poll_limit = PollLimitReset;
         wait_mode = WAIT_IDLE;
         expected_byte = '0;
         poll_address = '0;
         prev_toggle = 1'b0;
         poll_count = '0;
         expected_bus_ops.delete();
         mismatch_count = 0;
         request_count = 0;
         result_count = 0;
         done_count = 0;
         timeout_count = 0;
         reject_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_UNLOCK_FIRST:  unlock_first = csr_wdata[AddrWidth-1:0];
               CSR_UNLOCK_SECOND: unlock_second = csr_wdata[AddrWidth-1:0];
               CSR_POLL_LIMIT:    poll_limit = csr_wdata[CountWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (expected_bus_ops.size() == 0) begin
               report_mismatch("result with nothing pending, kind", 32'(rsp_ch.kind), '0);
            end else begin
               want = expected_bus_ops.pop_front();
               if (rsp_ch.kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_ch.kind), 32'(want.kind));
               if (rsp_ch.bus_address !== want.addr)
                  report_mismatch("bus_address", 32'(rsp_ch.bus_address), 32'(want.addr));
               if (rsp_ch.bus_data !== want.data)
                  report_mismatch("bus_data", 32'(rsp_ch.bus_data), 32'(want.data));
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", 32'(rsp_ch.last), 32'(want.last));
               case (want.kind)
                  KIND_DONE:    done_count++;
                  KIND_TIMEOUT: timeout_count++;
                  KIND_REJECT:  reject_count++;
                  default: ;
               endcase
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            request_count++;
            predict_bus_sequence(req_ch.op, req_ch.address, req_ch.data);
         end
      end
      outstanding_count = expected_bus_ops.size();
   end

endmodule

FILE: verif/tb_nor_flash_command_sequencer.sv
module tb_nor_flash_command_sequencer;
   import nfcs_pkg::*;

   localparam int IdleLimit = 3000;
   localparam int RspHoldCycles = 300;
   localparam int DrainCycles = MaxResults * 4;
   localparam int PhaseItems = 52;
   localparam logic [AddrWidth-1:0] AddrAllOnes = '1;
   localparam logic [DataWidth-1:0] DataAllOnes = '1;
   localparam logic [DataWidth-1:0] ToggleMask = DataWidth'(1 << ToggleBit);
   localparam logic [DataWidth-1:0] ReadyMask = DataWidth'(1 << ReadyBit);
   localparam logic [CsrDataWidth-1:0] CsrAllOnes = '1;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   int  mismatch_count;
   int  outstanding_count;
   int  request_count;
   int  result_count;
   int  done_count;
   int  timeout_count;
   int  reject_count;
   int  sent_count;
   int  setting_count;
   int  req_idle_pct;
   int  quiet_cycles;
   int  hold_requests;

   nfcs_req_if req_ch();
   nfcs_rsp_if rsp_ch();

   nor_flash_command_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nfcs_bus_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count),
      .request_count     (request_count),
      .result_count      (result_count),
      .done_count        (done_count),
      .timeout_count     (timeout_count),
      .reject_count      (reject_count)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one request and hold it until taken
   task automatic send_request(logic [OpWidth-1:0] op, logic [AddrWidth-1:0] addr,
                               logic [DataWidth-1:0] data);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < req_idle_pct)
         gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         req_ch.op <= OpWidth'($urandom);
         req_ch.address <= AddrWidth'($urandom);
         req_ch.data <= DataWidth'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.address <= addr;
      req_ch.data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // stop offering and let every pending result come out
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding_count != 0) @(negedge clock);
      repeat (MaxResults) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_setting(logic [CsrDataWidth-1:0] first, logic [CsrDataWidth-1:0] second,
                                logic [CsrDataWidth-1:0] limit);
      wait_drained();
      write_register(CSR_UNLOCK_FIRST, first);
      write_register(CSR_UNLOCK_SECOND, second);
      write_register(CSR_POLL_LIMIT, limit);
      setting_count++;
   endtask

   // one command with its polling replies, or a stray request
   task automatic run_flash_sequence();
      int                   pick;
      int                   polls;
      logic [AddrWidth-1:0] target;
      logic [DataWidth-1:0] byte_value;
      logic [DataWidth-1:0] status;
      logic                 toggle;
      case ($urandom_range(0, 2))
         0: req_idle_pct = 0;
         1: req_idle_pct = 20;
         default: req_idle_pct = 50;
      endcase
      pick = $urandom_range(0, 99);
      target = AddrWidth'($urandom);
      byte_value = DataWidth'($urandom);
      polls = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      if (pick < 30) begin
         send_request(OP_PROGRAM, target, byte_value);
         repeat (polls) begin
            status = byte_value ^ DataWidth'($urandom_range(1, 255));
            send_request(OP_READ_DATA, AddrWidth'($urandom), status);
         end
         send_request(OP_READ_DATA, AddrWidth'($urandom), byte_value);
      end else if (pick < 50) begin
         send_request(OP_SECTOR_ERASE, target, byte_value);
         status = DataWidth'($urandom);
         toggle = status[ToggleBit];
         send_request(OP_READ_DATA, AddrWidth'($urandom), status);
         repeat (polls) begin
            toggle = !toggle;
            status = DataWidth'($urandom);
            status[ToggleBit] = toggle;
            send_request(OP_READ_DATA, AddrWidth'($urandom), status);
         end
         status = DataWidth'($urandom);
         status[ToggleBit] = toggle;
         send_request(OP_READ_DATA, AddrWidth'($urandom), status);
      end else if (pick < 68) begin
         send_request(OP_CHIP_ERASE, target, byte_value);
         repeat (polls) begin
            status = DataWidth'($urandom);
            status[ReadyBit] = 1'b0;
            send_request(OP_READ_DATA, AddrWidth'($urandom), status);
         end
         status = DataWidth'($urandom);
         status[ReadyBit] = 1'b1;
         send_request(OP_READ_DATA, AddrWidth'($urandom), status);
      end else if (pick < 76) begin
         send_request(OP_RESET_READ, target, byte_value);
      end else if (pick < 81) begin
         // broken sequence: command and up to two replies, then abandoned
         send_request(OpWidth'($urandom_range(0, 2)), target, byte_value);
         repeat ($urandom_range(0, 2))
            send_request(OP_READ_DATA, AddrWidth'($urandom), DataWidth'($urandom));
      end else begin
         send_request(OpWidth'($urandom), target, byte_value);
      end
   endtask

   task automatic run_random_phase(int items);
      int stop_at;
      stop_at = sent_count + items;
      while (sent_count < stop_at) run_flash_sequence();
   endtask

   // result receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall_left;
      int hold_left;
      int window;
      int rsp_idle_pct;
      int holds_served;
      stall_left = 0;
      hold_left = 0;
      window = 0;
      rsp_idle_pct = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            window = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 15;
               default: rsp_idle_pct = 40;
            endcase
         end
         window--;
         if (hold_requests != holds_served) begin
            hold_left = RspHoldCycles;
            holds_served = hold_requests;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ch.ready <= 1'b0;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == IdleLimit) begin
            $display("watchdog: nothing moved for %0d cycles", IdleLimit);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_UNLOCK_FIRST;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_PROGRAM;
      req_ch.address = '0;
      req_ch.data = '0;
      hold_requests = 0;
      req_idle_pct = 30;
      sent_count = 0;
      setting_count = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray status byte, unknown ops, reset to read
      send_request(OP_READ_DATA, AddrAllOnes, DataAllOnes);
      for (int k = int'(OP_READ_DATA) + 1; k < (1 << OpWidth); k++)
         send_request(OpWidth'(k), AddrAllOnes, DataAllOnes);
      send_request(OP_RESET_READ, AddrAllOnes, DataAllOnes);
      // program at the top address with a command arriving mid-wait
      send_request(OP_PROGRAM, AddrAllOnes, DataAllOnes);
      send_request(OP_READ_DATA, '0, '0);
      send_request(OP_SECTOR_ERASE, '0, '0);
      send_request(OP_READ_DATA, '0, DataAllOnes);
      send_request(OP_PROGRAM, '0, '0);
      send_request(OP_READ_DATA, AddrAllOnes, '0);
      // sector erase: reference read, one toggle, then settled
      send_request(OP_SECTOR_ERASE, AddrAllOnes, '0);
      send_request(OP_READ_DATA, '0, ToggleMask);
      send_request(OP_READ_DATA, '0, '0);
      send_request(OP_READ_DATA, '0, '0);
      // chip erase: busy then ready
      send_request(OP_CHIP_ERASE, '0, DataAllOnes);
      send_request(OP_READ_DATA, '0, ~ReadyMask);
      send_request(OP_READ_DATA, '0, ReadyMask);

      // single counted poll: every wait times out on its first miss
      apply_setting(CsrAllOnes, '0, CsrDataWidth'(1));
      send_request(OP_PROGRAM, AddrAllOnes, 8'h5A);
      send_request(OP_READ_DATA, '0, 8'hA5);
      send_request(OP_SECTOR_ERASE, '0, '0);
      send_request(OP_READ_DATA, '0, '0);
      send_request(OP_READ_DATA, '0, ToggleMask);
      send_request(OP_CHIP_ERASE, '0, '0);
      send_request(OP_READ_DATA, '0, '0);
      run_random_phase(PhaseItems);

      // unlock offsets at both extremes, receiver held off while requests queue up
      apply_setting('0, CsrDataWidth'(AddrAllOnes), CsrDataWidth'(4));
      hold_requests++;
      run_random_phase(PhaseItems);

      // poll limit of zero
      apply_setting(CsrDataWidth'($urandom), CsrDataWidth'($urandom), '0);
      run_random_phase(PhaseItems);

      // largest poll limit
      apply_setting(CsrDataWidth'($urandom), CsrDataWidth'($urandom), CsrAllOnes);
      run_random_phase(PhaseItems);

      // default offsets, short random limit
      apply_setting(CsrDataWidth'(UnlockFirstReset), CsrDataWidth'(UnlockSecondReset),
                    CsrDataWidth'($urandom_range(2, 6)));
      run_random_phase(PhaseItems);

      wait_drained();
      repeat (DrainCycles) @(negedge clock);

      $display("covered %0d requests and %0d results under %0d register settings",
               request_count, result_count, setting_count);
      $display("outcomes: %0d done, %0d timeout, %0d rejected, %0d mismatches",
               done_count, timeout_count, reject_count, mismatch_count);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: files.f
src/nfcs_pkg.sv
src/nfcs_req_if.sv
src/nfcs_rsp_if.sv
src/nor_flash_command_sequencer.sv
verif/nfcs_bus_checker.sv
verif/tb_nor_flash_command_sequencer.sv
